// ===== sv/dmds_pkg.sv =====
// ----------------------------------------------------------------------------
// Display mode catalogue package
// Shared widths, the sort key layout and the controller/datapath interface.
// ----------------------------------------------------------------------------
package dmds_pkg;

    localparam int MAX_MODES = 64;
    localparam int OUT_LIMIT = 64;

    localparam int W_BITS    = 14;
    localparam int H_BITS    = 14;
    localparam int R_BITS    = 10;
    localparam int AREA_BITS = W_BITS + H_BITS;
    localparam int MODE_BITS = W_BITS + H_BITS + R_BITS;
    localparam int KEY_BITS  = AREA_BITS + MODE_BITS;

    // Key layout, most significant first: area, width, height, rate.
    // An unsigned compare of two keys gives the catalogue order directly.
    localparam int R_LSB = 0;
    localparam int H_LSB = R_BITS;
    localparam int W_LSB = R_BITS + H_BITS;

    localparam int IDX_W    = (MAX_MODES > 1) ? $clog2(MAX_MODES) : 1;
    localparam int CNT_W    = $clog2(MAX_MODES + 1);
    localparam int EMIT_MAX = (MAX_MODES < OUT_LIMIT) ? MAX_MODES : OUT_LIMIT;
    localparam int EMIT_W   = $clog2(EMIT_MAX + 1);

    typedef logic [KEY_BITS-1:0] key_t;

    typedef enum logic {
        SCAN_DUP,
        SCAN_SORT
    } scan_t;

    typedef struct packed {
        logic             load;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        scan_t            rd_mode;
        logic             insert;
        logic             best_clr;
        logic             emit_pop;
        logic             finish;
    } cmd_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic             final_flag;
        logic             last_out;
    } status_t;

endpackage

// ===== sv/dmds_datapath.sv =====
// ----------------------------------------------------------------------------
// Display mode catalogue datapath
// Mode store, duplicate compare, best-candidate selection and output registers.
// ----------------------------------------------------------------------------
module dmds_datapath (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [dmds_pkg::W_BITS-1:0]  mode_width,
    input  logic [dmds_pkg::H_BITS-1:0]  mode_height,
    input  logic [dmds_pkg::R_BITS-1:0]  mode_rate,
    input  logic                         final_mode,
    input  dmds_pkg::cmd_t               cmd,
    output dmds_pkg::status_t            status,
    output logic [dmds_pkg::W_BITS-1:0]  out_width,
    output logic [dmds_pkg::H_BITS-1:0]  out_height,
    output logic [dmds_pkg::R_BITS-1:0]  out_rate,
    output logic                         new_resolution,
    output logic                         last_entry,
    output logic                         overflowed
);
    import dmds_pkg::*;

    key_t mem [MAX_MODES];

    key_t              in_key_reg;
    key_t              rdata_reg;
    key_t              best_reg;
    key_t              prev_reg;
    logic              final_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              ovf_reg;
    logic              dup_reg;
    logic              rvalid_reg;
    scan_t             rmode_reg;
    logic              best_vld_reg;
    logic              first_reg;
    logic [EMIT_W-1:0] emitted_reg;

    logic [AREA_BITS-1:0] area;
    logic                 has_room;
    logic                 write_en;
    logic                 dup_hit;
    logic                 cand_ok;
    logic                 cand_take;
    logic [EMIT_W-1:0]    emit_total;
    logic                 last_out;

    assign area      = AREA_BITS'(mode_width) * AREA_BITS'(mode_height);
    assign has_room  = count_reg < CNT_W'(MAX_MODES);
    assign write_en  = cmd.insert && !dup_reg && has_room;
    assign dup_hit   = rvalid_reg && (rmode_reg == SCAN_DUP)
                       && (rdata_reg[MODE_BITS-1:0] == in_key_reg[MODE_BITS-1:0]);
    // A candidate must rank strictly below the entry emitted before it.
    assign cand_ok   = first_reg || (rdata_reg < prev_reg);
    assign cand_take = rvalid_reg && (rmode_reg == SCAN_SORT) && cand_ok
                       && (!best_vld_reg || (rdata_reg > best_reg));

    assign emit_total = (count_reg > CNT_W'(EMIT_MAX)) ? EMIT_W'(EMIT_MAX)
                                                        : EMIT_W'(count_reg);
    assign last_out   = (emitted_reg + EMIT_W'(1)) == emit_total;

    assign status.count      = count_reg;
    assign status.final_flag = final_reg;
    assign status.last_out   = last_out;

    always_ff @(posedge clk) begin
        if (write_en) begin
            mem[count_reg[IDX_W-1:0]] <= in_key_reg;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge clk) begin
        if (cmd.load) begin
            in_key_reg <= {area, mode_width, mode_height, mode_rate};
        end
        if (cand_take) begin
            best_reg <= rdata_reg;
        end
        if (cmd.emit_pop) begin
            prev_reg <= best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            final_reg    <= 1'b0;
            count_reg    <= '0;
            ovf_reg      <= 1'b0;
            dup_reg      <= 1'b0;
            rvalid_reg   <= 1'b0;
            rmode_reg    <= SCAN_DUP;
            best_vld_reg <= 1'b0;
            first_reg    <= 1'b1;
            emitted_reg  <= '0;
        end
        else begin
            rvalid_reg <= cmd.rd_en;
            rmode_reg  <= cmd.rd_mode;
            if (cmd.load) begin
                final_reg <= final_mode;
                dup_reg   <= 1'b0;
            end
            else if (dup_hit) begin
                dup_reg <= 1'b1;
            end
            if (cmd.insert && !dup_reg) begin
                if (has_room) begin
                    count_reg <= count_reg + CNT_W'(1);
                end
                else begin
                    ovf_reg <= 1'b1;
                end
            end
            if (cmd.best_clr) begin
                best_vld_reg <= 1'b0;
            end
            else if (cand_take) begin
                best_vld_reg <= 1'b1;
            end
            if (cmd.finish) begin
                count_reg   <= '0;
                ovf_reg     <= 1'b0;
                first_reg   <= 1'b1;
                emitted_reg <= '0;
            end
            else if (cmd.emit_pop) begin
                first_reg   <= 1'b0;
                emitted_reg <= emitted_reg + EMIT_W'(1);
            end
        end
    end

    assign out_width      = best_reg[W_LSB +: W_BITS];
    assign out_height     = best_reg[H_LSB +: H_BITS];
    assign out_rate       = best_reg[R_LSB +: R_BITS];
    assign new_resolution = first_reg
                            || (best_reg[MODE_BITS-1:H_LSB] != prev_reg[MODE_BITS-1:H_LSB]);
    assign last_entry     = last_out;
    assign overflowed     = last_out && ovf_reg;

    // The store never holds more modes than it has room for.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_MODES))
        else $error("mode count exceeds store capacity");

    // A fresh mode with room grows the store by exactly one entry.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.insert && !dup_reg && has_room && !cmd.finish)
        |=> count_reg == $past(count_reg) + CNT_W'(1))
        else $error("insert did not grow the store");

    // A word is only ever popped while a selected candidate is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit_pop |-> (best_vld_reg && (emitted_reg < emit_total)))
        else $error("catalogue word popped without a valid candidate");

endmodule

// ===== sv/dmds_ctrl.sv =====
// ----------------------------------------------------------------------------
// Display mode catalogue controller
// Sequences duplicate scans, inserts, selection passes and output handshakes.
// ----------------------------------------------------------------------------
module dmds_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    input  dmds_pkg::status_t status,
    output dmds_pkg::cmd_t    cmd
);
    import dmds_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DUP_RD,
        ST_DUP_END,
        ST_INSERT,
        ST_SORT_RD,
        ST_SORT_END,
        ST_EMIT
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] idx_next;
    logic             scan_last;

    assign scan_last = (idx_reg + CNT_W'(1)) == status.count;
    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);

    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.rd_addr  = idx_reg[IDX_W-1:0];
        cmd.rd_mode  = SCAN_DUP;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    idx_next   = '0;
                    state_next = (status.count == '0) ? ST_INSERT : ST_DUP_RD;
                end
            end
            ST_DUP_RD: begin
                cmd.rd_en = 1'b1;
                if (scan_last) begin
                    state_next = ST_DUP_END;
                end
                else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_DUP_END: begin
                state_next = ST_INSERT;
            end
            ST_INSERT: begin
                cmd.insert = 1'b1;
                if (status.final_flag) begin
                    cmd.best_clr = 1'b1;
                    idx_next     = '0;
                    state_next   = ST_SORT_RD;
                end
                else begin
                    state_next = ST_IDLE;
                end
            end
            ST_SORT_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_mode = SCAN_SORT;
                if (scan_last) begin
                    state_next = ST_SORT_END;
                end
                else begin
                    idx_next = idx_reg + CNT_W'(1);
                end
            end
            ST_SORT_END: begin
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_ready) begin
                    cmd.emit_pop = 1'b1;
                    if (status.last_out) begin
                        cmd.finish = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else begin
                        cmd.best_clr = 1'b1;
                        idx_next     = '0;
                        state_next   = ST_SORT_RD;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Every read issued by a scan falls inside the filled part of the store.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rd_en |-> (idx_reg < status.count))
        else $error("scan read beyond the filled entries");

    // The catalogue is closed only together with the pop of its last word.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (cmd.emit_pop && status.last_out))
        else $error("catalogue closed without its last word");

    // A stalled result keeps the controller parked on it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while the receiver stalled");

endmodule

// ===== sv/display_mode_dedup_sort_top.sv =====
// ----------------------------------------------------------------------------
// Display mode catalogue with duplicate removal and sorted output
// Collects distinct display modes and emits them as one sorted catalogue.
// ----------------------------------------------------------------------------
// Usage: modes enter one word at a time on the input channel (in_valid and
// in_ready). Each distinct (width, height, rate) triple is kept once, up to
// MAX_MODES entries; a further distinct mode is dropped and remembered as an
// overflow. A word with final_mode set is stored first and then starts the
// catalogue: every held mode leaves on the output channel (out_valid and
// out_ready), largest pixel area first, wider first at equal area, then taller,
// and within one resolution the highest rate first. The first word of each
// resolution has new_resolution set; the last has last_entry set and carries
// overflowed. The store is then empty again.
// Timing: the duplicate check reads the single-port store one entry per cycle
// over all held modes before a word is stored, and is skipped for a word into
// an empty store. Each output word needs a selection scan over the same port
// across all held modes, and then waits while the receiver stalls.
// A stalled word stays on the outputs unchanged, and no input word is taken
// until the catalogue is out.
// Reset empties the store at once and clears the overflow flag; stored
// entries need no clearing pass since only filled entries are ever read.
// ----------------------------------------------------------------------------
module display_mode_dedup_sort_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [dmds_pkg::W_BITS-1:0]  mode_width,
    input  logic [dmds_pkg::H_BITS-1:0]  mode_height,
    input  logic [dmds_pkg::R_BITS-1:0]  mode_rate,
    input  logic                         final_mode,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [dmds_pkg::W_BITS-1:0]  out_width,
    output logic [dmds_pkg::H_BITS-1:0]  out_height,
    output logic [dmds_pkg::R_BITS-1:0]  out_rate,
    output logic                         new_resolution,
    output logic                         last_entry,
    output logic                         overflowed
);
    import dmds_pkg::*;

    // Commands flow from the controller, status flows back from the datapath.
    cmd_t    cmd;
    status_t status;

    dmds_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath captures the input word, with its pixel area, on acceptance.
    dmds_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .mode_width     (mode_width),
        .mode_height    (mode_height),
        .mode_rate      (mode_rate),
        .final_mode     (final_mode),
        .cmd            (cmd),
        .status         (status),
        .out_width      (out_width),
        .out_height     (out_height),
        .out_rate       (out_rate),
        .new_resolution (new_resolution),
        .last_entry     (last_entry),
        .overflowed     (overflowed)
    );

endmodule
